// ===== hdl/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths and constants of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_W = 31;
    localparam int OPD_W = 63;
    localparam int CNT_W = 6;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;
    localparam logic [CNT_W-1:0] RED_LAST      = CNT_W'(OPD_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST      = CNT_W'(MOD_W - 1);

endpackage

// ===== hdl/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base to the exponent modulo a configured modulus, right-to-left
// square-and-multiply on one bit-serial modular multiplier
// ----------------------------------------------------------------------------
// usage:
//   the modulus is written on the cfg channel (always ready); write it only
//   while no item is in flight, the block does not enforce this; reset loads
//   1000000007; an input item (base, exponent) is taken when i_in_valid and
//   o_in_ready are high; one item is worked on at a time
//   the base is first reduced one bit a cycle; then for each exponent bit the
//   accumulator is multiplied by the square when the bit is set, and the square
//   is squared while higher bits remain; every product goes through the shared
//   reducer one operand bit a cycle; for exponent 0 only the base reduction runs
//   the result sits in an output register; o_in_ready returns as soon as the
//   result is loaded, so the next item can start while the receiver stalls;
//   a finished item waits in its last state if the previous result was not
//   yet taken
//   reset clears the state machine and the output valid, nothing is pending afterwards
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mexp_pkg::MOD_W-1:0] i_modulus,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [mexp_pkg::OPD_W-1:0] i_base,
    input  logic [mexp_pkg::OPD_W-1:0] i_exponent,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mexp_pkg::MOD_W-1:0] o_power
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_SEL,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_ACC,
        OP_SQ
    } t_mul_op;

    t_state             r_state;
    t_mul_op            r_op;
    logic [MOD_W-1:0]   r_modulus;
    logic [OPD_W-1:0]   r_shift;
    logic [OPD_W-1:0]   r_exp;
    logic [MOD_W-1:0]   r_rem;
    logic [MOD_W-1:0]   r_mul_b;
    logic [MOD_W-1:0]   r_acc;
    logic [MOD_W-1:0]   r_sq;
    logic [CNT_W-1:0]   r_cnt;
    logic [MOD_W-1:0]   r_power;
    logic               r_out_valid;

    logic [MOD_W-1:0]   step_x;
    logic [MOD_W+1:0]   step_t;
    logic [MOD_W+2:0]   step_d1;
    logic [MOD_W+2:0]   step_d2;
    logic [MOD_W-1:0]   n_rem;

    // one shift-add-reduce step: rem = (2 * rem + x) mod m, with 2*rem + x < 3m
    always_comb begin
        if (r_state == S_RED) begin
            step_x = {{(MOD_W-1){1'b0}}, r_shift[OPD_W-1]};
        end else begin
            step_x = r_shift[OPD_W-1] ? r_mul_b : '0;
        end
        step_t  = {1'b0, r_rem, 1'b0} + {2'b00, step_x};
        step_d1 = {1'b0, step_t} - {3'b000, r_modulus};
        step_d2 = {1'b0, step_t} - {2'b00, r_modulus, 1'b0};
        priority if (!step_d2[MOD_W+2]) begin
            n_rem = step_d2[MOD_W-1:0];
        end else if (!step_d1[MOD_W+2]) begin
            n_rem = step_d1[MOD_W-1:0];
        end else begin
            n_rem = step_t[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_modulus <= i_modulus;
            end
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_shift <= i_base;
                        r_rem   <= '0;
                        r_cnt   <= RED_LAST;
                        // a zero modulus gives 0 without any exponent steps
                        r_exp   <= (r_modulus == '0) ? '0 : i_exponent;
                        r_acc   <= (r_modulus == MOD_W'(1) || r_modulus == '0)
                                   ? '0 : MOD_W'(1);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_rem   <= n_rem;
                    r_shift <= {r_shift[OPD_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_sq    <= n_rem;
                        r_state <= S_SEL;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_SEL: begin
                    r_rem <= '0;
                    r_cnt <= MUL_LAST;
                    priority if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_shift  <= {r_acc, {(OPD_W-MOD_W){1'b0}}};
                        r_mul_b  <= r_sq;
                        r_op     <= OP_ACC;
                        r_exp[0] <= 1'b0;
                        r_state  <= S_MUL;
                    end else begin
                        r_exp <= {1'b0, r_exp[OPD_W-1:1]};
                        if (r_exp[OPD_W-1:1] == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_shift <= {r_sq, {(OPD_W-MOD_W){1'b0}}};
                            r_mul_b <= r_sq;
                            r_op    <= OP_SQ;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_rem   <= n_rem;
                    r_shift <= {r_shift[OPD_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        if (r_op == OP_ACC) begin
                            r_acc <= n_rem;
                        end else begin
                            r_sq <= n_rem;
                        end
                        r_state <= S_SEL;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_power     <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_power     = r_power;

    // assertions
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is still in work");

    a_mul_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= MUL_LAST))
        else $error("multiply step count out of range");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

endmodule

// ===== test/modular_exponentiation_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top_tb
// checks every power against a square-and-multiply predictor kept per
// item; directed corner items, then random phases over several moduli,
// with random gaps on both sides, a long output hold-off and drain pauses
// ----------------------------------------------------------------------------
module modular_exponentiation_top_tb;
    import mexp_pkg::*;

    typedef logic [MOD_W-1:0] t_mod;
    typedef logic [OPD_W-1:0] t_opd;

    localparam t_opd OPD_MAX    = {OPD_W{1'b1}};
    localparam t_mod MOD_MAX    = {MOD_W{1'b1}};
    localparam int   IDLE_LIMIT = 50000;
    localparam int   HOLD_LEN   = 3000;

    class power_board;
        t_mod powers_q[$];
        int   errors = 0;

        function t_mod mod_pow(t_opd b, t_opd e, t_mod m);
            bit [63:0] acc;
            bit [63:0] sq;
            bit [63:0] mm;
            t_opd      bits;
            if (m == '0) return '0;
            mm   = 64'(m);
            acc  = (m != 1) ? 64'd1 : 64'd0;
            sq   = 64'(b) % mm;
            bits = e;
            while (bits != '0) begin
                if (bits[0]) acc = (acc * sq) % mm;
                sq   = (sq * sq) % mm;
                bits = bits >> 1;
            end
            return t_mod'(acc);
        endfunction

        function void note_input(t_opd b, t_opd e, t_mod m);
            powers_q.insert(powers_q.size(), mod_pow(b, e, m));
        endfunction

        function void check_power(t_mod got);
            t_mod want;
            if (powers_q.size() == 0) begin
                $error("power: no item expected, expected none, actual %0d", got);
                errors++;
                return;
            end
            want = powers_q.pop_front();
            if (want !== got) begin
                $error("power: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return powers_q.size();
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    t_mod i_modulus   = '0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_opd i_base      = '0;
    t_opd i_exponent  = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_mod o_power;

    power_board powers = new();
    t_mod       live_modulus = MODULUS_RESET;
    bit         hold_req = 1'b0;
    int         idle_cycles = 0;

    modular_exponentiation_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_modulus   (i_modulus),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_power     (o_power)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) powers.note_input(i_base, i_exponent, live_modulus);
            if (o_out_valid && i_out_ready) powers.check_power(o_power);
            if (i_cfg_valid && o_cfg_ready) live_modulus <= i_modulus;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("modular_exponentiation_top_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver
    initial begin
        int r;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (r < 95) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(50, 400)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_opd rand_exponent();
        int r;
        int w;
        r = $urandom_range(0, 99);
        if (r < 70) w = $urandom_range(0, 12);
        else if (r < 90) w = $urandom_range(13, 32);
        else w = $urandom_range(33, OPD_W);
        if (w == 0) return '0;
        return t_opd'(rand64() >> (64 - w));
    endfunction

    function automatic t_opd rand_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return t_opd'(rand64());
        if (r < 70) return t_opd'($urandom_range(0, 1000));
        if (r < 85) return t_opd'(64'(live_modulus) * $urandom_range(0, 3) + $urandom_range(0, 2));
        return t_opd'(rand64() >> $urandom_range(1, 63));
    endfunction

    task automatic send_item(t_opd b, t_opd e, bit with_gap);
        int r;
        int gap;
        i_in_valid <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        do @(posedge i_clk); while (!o_in_ready);
        if (with_gap) begin
            r = $urandom_range(0, 99);
            if (r < 55) gap = 0;
            else if (r < 90) gap = $urandom_range(1, 4);
            else gap = $urandom_range(20, 200);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (powers.pending() != 0);
    endtask

    task automatic set_modulus(t_mod m);
        settle();
        i_cfg_valid <= 1'b1;
        i_modulus   <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_mod m;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus
        send_item('0, '0, 1'b1);
        send_item('0, 1, 1'b1);
        send_item(1, '0, 1'b1);
        send_item(OPD_MAX, OPD_MAX, 1'b1);
        send_item(OPD_MAX, '0, 1'b1);
        send_item('0, OPD_MAX, 1'b1);
        send_item(2, 10, 1'b1);
        send_item(2, 1000000006, 1'b1);
        send_item(1000000007, 5, 1'b1);
        send_item(1000000008, 3, 1'b1);
        send_item(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1);
        send_item(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b1);

        set_modulus(MOD_MAX);
        send_item(2147483646, 2, 1'b1);
        send_item(2147483646, OPD_MAX, 1'b1);
        send_item(OPD_MAX, 1, 1'b1);
        send_item(7, 2147483646, 1'b1);

        // modulus of one
        set_modulus(1);
        send_item(7, '0, 1'b1);
        send_item(OPD_MAX, OPD_MAX, 1'b1);
        send_item('0, '0, 1'b1);

        // zero modulus
        set_modulus('0);
        send_item(5, 3, 1'b1);
        send_item('0, '0, 1'b1);

        set_modulus(2);
        send_item(3, '0, 1'b1);
        send_item(OPD_MAX, 5, 1'b1);
        send_item(4, 7, 1'b1);

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: m = t_mod'($urandom()) | {1'b1, {(MOD_W-1){1'b0}}};
                1: m = t_mod'($urandom_range(2, 1000));
                2: m = MOD_MAX;
                3: m = t_mod'($urandom());
                4: m = 1;
                5: m = 2;
                default: m = t_mod'($urandom()) & {1'b0, {(MOD_W-1){1'b1}}};
            endcase
            set_modulus(m);
            if (p == 1) begin
                // output held off while items keep coming
                hold_req = 1'b1;
                for (int k = 0; k < 10; k++)
                    send_item(rand_base(), t_opd'($urandom_range(0, 255)), 1'b0);
            end
            for (int k = 0; k < 15; k++) send_item(rand_base(), rand_exponent(), 1'b1);
        end

        settle();
        repeat (200) @(posedge i_clk);
        if (powers.errors == 0 && powers.pending() == 0) begin
            $display("modular_exponentiation_top_tb: done, clean");
        end else begin
            $display("modular_exponentiation_top_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mexp_pkg.sv
hdl/modular_exponentiation_top.sv
test/modular_exponentiation_top_tb.sv
